/* rtl/core/skc_pkg.sv */
// skc_pkg: constants, state codes and the log2 lookup table for the
// soft-knee compressor gain computer. no dependencies.
`default_nettype none

package skc_pkg;

    localparam int SAMPLE_BITS      = 24;
    localparam int HPF_FRAC         = 32 - SAMPLE_BITS;
    localparam int S_TDATA_W        = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W        = 40;
    localparam int DB_LOG2          = 8;
    localparam int DB_TABLE_ENTRIES = 1 << DB_LOG2;
    localparam int DIV_Q            = 25;

    localparam logic [1:0] MODE_FAST    = 2'd0;
    localparam logic [1:0] MODE_OPTO    = 2'd1;
    localparam logic [1:0] MODE_PROGRAM = 2'd2;

    localparam logic signed [23:0] FLOOR_DB_Q16    = -24'sd6553600;
    localparam logic [26:0]        DB_PER_OCT_Q24  = 27'd101008905;
    localparam logic signed [32:0] OFFSET31_Q16    = 33'sd2031616;
    localparam logic signed [32:0] OFFSET16_Q16    = 33'sd1048576;
    localparam logic [23:0]        ONE_Q16         = 24'd65536;
    localparam logic [23:0]        RATIO_MIN_Q16   = 24'd78643;
    localparam logic [23:0]        RATIO_BASE_Q16  = 24'd98304;
    localparam logic [26:0]        RATIO_SLOPE_Q16 = 27'd14418;
    localparam logic [23:0]        KNEE_FAST_Q16   = 24'd262144;
    localparam logic [23:0]        KNEE_OPTO_Q16   = 24'd655360;
    localparam logic [23:0]        KNEE_PROG_Q16   = 24'd917504;
    localparam logic [23:0]        RATIO_RESET_Q16 = 24'd131072;

    typedef enum logic [2:0] {
        REG_MODE,
        REG_THRESHOLD,
        REG_RATIO,
        REG_ATTACK,
        REG_RELEASE,
        REG_HPF,
        REG_SMOOTH
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_HPF_MUL,
        ST_HPF_UPD,
        ST_DET,
        ST_ENV_MUL,
        ST_ENV_UPD,
        ST_NORM,
        ST_LOG_MUL,
        ST_LOG_SUM,
        ST_DB_MUL,
        ST_DB_UPD,
        ST_OVER,
        ST_RT_MUL,
        ST_RT,
        ST_R_MUL,
        ST_R_UPD,
        ST_K_MUL,
        ST_K_UPD,
        ST_P2_MUL,
        ST_P2_DIV,
        ST_DIV,
        ST_RED_MUL,
        ST_RED_DIV,
        ST_MAG,
        ST_SEARCH_CHK,
        ST_DONE
    } state_t;

    typedef logic [16:0] log_tab_t [0:DB_TABLE_ENTRIES];

    // log2(1 + i/N) in Q.16, truncating bit-serial squaring
    function automatic log_tab_t build_log_tab();
        log_tab_t    tab;
        logic [63:0] y;
        logic [16:0] res;
        for (int i = 0; i <= DB_TABLE_ENTRIES; i++) begin
            y   = (64'd1 << 30) + ((64'(i) << 30) >> DB_LOG2);
            res = '0;
            if (y >= (64'd1 << 31)) begin
                res = 17'd65536;
            end else begin
                for (int k = 15; k >= 0; k--) begin
                    y = (y * y) >> 30;
                    if (y >= (64'd1 << 31)) begin
                        y      = y >> 1;
                        res[k] = 1'b1;
                    end
                end
            end
            tab[i] = res;
        end
        return tab;
    endfunction

    localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

`default_nettype wire

/* rtl/core/soft_knee_compressor_gain.sv */
// soft_knee_compressor_gain: sidechain detector, dB conversion, soft knee and
// gain search around one shared multiplier and a restoring divider. uses skc_pkg.
//
// One sidechain sample per beat goes in, one gain beat comes out. A sample passes
// through the high-pass, envelope, level, ratio and knee steps (a zero envelope
// skips the log, and each of two 25-step divisions runs when the knee or the
// reduction needs it), then a 16 or 17 step binary search for the linear gain,
// each step a normalization and two passes through the shared multiplier; then
// the search closes, the output is loaded and the block returns to idle. s_tready
// is high only while the block waits for a sample; a finished result waits in the
// output register. Configuration writes are taken at any time on the cfg channel
// and should be made while idle.
`default_nettype none

module soft_knee_compressor_gain
    import skc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // sample
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // gain [16:0], reduction_db [32:17], zero pad
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [23:0]          cfg_data
);

    state_t state_reg, state_next;

    logic [1:0]         mode_reg, mode_next;
    logic signed [15:0] thr_reg, thr_next;
    logic [12:0]        ratio_reg, ratio_next;
    logic [23:0]        atk_reg, atk_next;
    logic [23:0]        rel_reg, rel_next;
    logic [23:0]        hpfc_reg, hpfc_next;
    logic [23:0]        smc_reg, smc_next;

    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] hpf_reg, hpf_next;
    logic [31:0]        det_reg, det_next;
    logic [31:0]        env_reg, env_next;
    logic [23:0]        ratio_now_reg, ratio_now_next;
    logic [23:0]        knee_now_reg, knee_now_next;

    logic signed [60:0] prod_reg, prod_next;
    logic [31:0]        norm_reg, norm_next;
    logic [4:0]         expo_reg, expo_next;
    logic [2:0]         step_reg, step_next;
    logic [21:0]        lg_reg, lg_next;
    logic               search_reg, search_next;
    logic signed [23:0] level_reg, level_next;
    logic signed [24:0] over_reg, over_next;
    logic [23:0]        rt_reg, rt_next;
    logic [23:0]        comp_reg, comp_next;
    logic [51:0]        rem_reg, rem_next;
    logic [51:0]        dsr_reg, dsr_next;
    logic [24:0]        quo_reg, quo_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               dsel_reg, dsel_next;
    logic [15:0]        mag_reg, mag_next;
    logic [16:0]        lo_reg, lo_next;
    logic [16:0]        hi_reg, hi_next;
    logic [16:0]        mid_reg, mid_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // shared multiplier
    logic signed [32:0] mul_a;
    logic [26:0]        mul_b;
    logic               mul_en;

    logic signed [60:0] rnd24_full;
    logic signed [36:0] q24;
    logic signed [60:0] rnd16_full;
    logic [22:0]        rp;
    logic signed [60:0] rnd31_full;
    logic [16:0]        frac;
    logic [DB_LOG2-1:0] ti;
    logic [DB_LOG2:0]   ti_lo, ti_hi;
    logic [16:0]        tab_lo, tab_hi;
    logic [30:0]        rr;
    logic signed [37:0] hsum, esum, rsum, ksum;
    logic signed [32:0] hdiff;
    logic [32:0]        hdabs;
    logic [31:0]        e_new, coef;
    logic [23:0]        k_new, rprog, rq, rtgt, ktgt;
    logic signed [25:0] two_over, ksn, ksr, p2;
    logic signed [36:0] tgt;
    logic [24:0]        mr_full;
    logic [16:0]        mr;
    logic [17:0]        mid_sum;
    logic               ge;
    logic [51:0]        rem_sub;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_OPTO;
            thr_reg       <= -16'sd4608;
            ratio_reg     <= 13'd512;
            atk_reg       <= 24'd16742320;
            rel_reg       <= 24'd16773726;
            hpfc_reg      <= 24'd43857;
            smc_reg       <= 24'd13976;
            hpf_reg       <= '0;
            env_reg       <= '0;
            ratio_now_reg <= RATIO_RESET_Q16;
            knee_now_reg  <= KNEE_OPTO_Q16;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            thr_reg       <= thr_next;
            ratio_reg     <= ratio_next;
            atk_reg       <= atk_next;
            rel_reg       <= rel_next;
            hpfc_reg      <= hpfc_next;
            smc_reg       <= smc_next;
            hpf_reg       <= hpf_next;
            env_reg       <= env_next;
            ratio_now_reg <= ratio_now_next;
            knee_now_reg  <= knee_now_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg       <= x_next;
        det_reg     <= det_next;
        prod_reg    <= prod_next;
        norm_reg    <= norm_next;
        expo_reg    <= expo_next;
        step_reg    <= step_next;
        lg_reg      <= lg_next;
        search_reg  <= search_next;
        level_reg   <= level_next;
        over_reg    <= over_next;
        rt_reg      <= rt_next;
        comp_reg    <= comp_next;
        rem_reg     <= rem_next;
        dsr_reg     <= dsr_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        dsel_reg    <= dsel_next;
        mag_reg     <= mag_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        thr_next       = thr_reg;
        ratio_next     = ratio_reg;
        atk_next       = atk_reg;
        rel_next       = rel_reg;
        hpfc_next      = hpfc_reg;
        smc_next       = smc_reg;
        x_next         = x_reg;
        hpf_next       = hpf_reg;
        det_next       = det_reg;
        env_next       = env_reg;
        ratio_now_next = ratio_now_reg;
        knee_now_next  = knee_now_reg;
        prod_next      = prod_reg;
        norm_next      = norm_reg;
        expo_next      = expo_reg;
        step_next      = step_reg;
        lg_next        = lg_reg;
        search_next    = search_reg;
        level_next     = level_reg;
        over_next      = over_reg;
        rt_next        = rt_reg;
        comp_next      = comp_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        dsel_next      = dsel_reg;
        mag_next       = mag_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        mul_a          = '0;
        mul_b          = '0;
        mul_en         = 1'b0;

        // rounded views of the last product
        rnd24_full = (prod_reg + 61'sd8388608) >>> 24;
        q24        = $signed(rnd24_full[36:0]);
        rnd16_full = (prod_reg + 61'sd32768) >>> 16;
        rp         = rnd16_full[22:0];
        rnd31_full = (prod_reg + 61'sd1073741824) >>> 31;
        frac       = rnd31_full[16:0];

        // table lookup from the normalized mantissa
        ti     = norm_reg[30 -: DB_LOG2];
        ti_lo  = {1'b0, ti};
        ti_hi  = ti_lo + (DB_LOG2 + 1)'(1);
        tab_lo = LOG_TAB[ti_lo];
        tab_hi = LOG_TAB[ti_hi];
        rr     = norm_reg[30:0] << DB_LOG2;

        hsum  = 38'(hpf_reg) + 38'(q24);
        hdiff = 33'(x_reg) - 33'(hpf_reg);
        hdabs = hdiff[32] ? 33'(-hdiff) : 33'(hdiff);
        coef  = (det_reg > env_reg) ? 32'(atk_reg) : 32'(rel_reg);
        esum  = $signed({6'b0, env_reg}) + 38'(q24);
        e_new = esum[37] ? 32'd0 : ((esum > 38'sh0FFFFFFFF) ? 32'hFFFFFFFF : esum[31:0]);
        rsum  = $signed({14'b0, ratio_now_reg}) + 38'(q24);
        ksum  = $signed({14'b0, knee_now_reg}) + 38'(q24);
        k_new = ksum[37] ? 24'd0 : ((ksum > 38'sh0FFFFFF) ? 24'hFFFFFF : ksum[23:0]);

        rq    = 24'({ratio_reg, 8'h00});
        rprog = RATIO_BASE_Q16 + 24'(rp);
        if (mode_reg == MODE_PROGRAM) begin
            if (rprog < RATIO_MIN_Q16) begin
                rtgt = RATIO_MIN_Q16;
            end else if (rprog > rq) begin
                rtgt = rq;
            end else begin
                rtgt = rprog;
            end
        end else begin
            rtgt = rq;
        end
        if (rtgt < ONE_Q16) begin
            rtgt = ONE_Q16;
        end
        case (mode_reg)
            MODE_FAST:    ktgt = KNEE_FAST_Q16;
            MODE_PROGRAM: ktgt = KNEE_PROG_Q16;
            default:      ktgt = KNEE_OPTO_Q16;
        endcase

        two_over = $signed({over_reg, 1'b0});
        ksn      = $signed({2'b00, k_new});
        ksr      = $signed({2'b00, knee_now_reg});
        p2       = two_over + ksr;
        tgt      = $signed(37'd0) - $signed(37'({mag_reg, 8'h00}));
        mr_full  = 25'(quo_reg[23:0]) + 25'd128;
        mr       = mr_full[24:8];
        mid_sum  = 18'(lo_reg) + 18'(hi_reg) + 18'd1;
        ge       = (rem_reg >= dsr_reg);
        rem_sub  = rem_reg - dsr_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_MODE:      mode_next  = cfg_data[1:0];
                REG_THRESHOLD: thr_next   = $signed(cfg_data[15:0]);
                REG_RATIO:     ratio_next = cfg_data[12:0];
                REG_ATTACK:    atk_next   = cfg_data;
                REG_RELEASE:   rel_next   = cfg_data;
                REG_HPF:       hpfc_next  = cfg_data;
                REG_SMOOTH:    smc_next   = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    x_next     = 32'(s_tdata[SAMPLE_BITS-1:0]) << HPF_FRAC;
                    state_next = ST_HPF_MUL;
                end
            end
            ST_HPF_MUL: begin
                mul_a      = hdiff;
                mul_b      = 27'(hpfc_reg);
                mul_en     = 1'b1;
                state_next = ST_HPF_UPD;
            end
            ST_HPF_UPD: begin
                if (hsum > 38'sd2147483647) begin
                    hpf_next = 32'sh7FFFFFFF;
                end else if (hsum < -38'sd2147483648) begin
                    hpf_next = 32'sh80000000;
                end else begin
                    hpf_next = $signed(hsum[31:0]);
                end
                state_next = ST_DET;
            end
            ST_DET: begin
                det_next   = hdabs[32] ? 32'hFFFFFFFF : hdabs[31:0];
                state_next = ST_ENV_MUL;
            end
            ST_ENV_MUL: begin
                mul_a      = $signed(33'(det_reg)) - $signed(33'(env_reg));
                mul_b      = 27'(33'h1000000 - 33'(coef));
                mul_en     = 1'b1;
                state_next = ST_ENV_UPD;
            end
            ST_ENV_UPD: begin
                env_next = e_new;
                if (e_new == 32'd0) begin
                    level_next = FLOOR_DB_Q16;
                    state_next = ST_OVER;
                end else begin
                    norm_next   = e_new;
                    expo_next   = 5'd31;
                    step_next   = '0;
                    search_next = 1'b0;
                    state_next  = ST_NORM;
                end
            end
            ST_NORM: begin
                case (step_reg)
                    3'd0: begin
                        if (norm_reg[31:16] == '0) begin
                            norm_next = norm_reg << 16;
                            expo_next = expo_reg - 5'd16;
                        end
                    end
                    3'd1: begin
                        if (norm_reg[31:24] == '0) begin
                            norm_next = norm_reg << 8;
                            expo_next = expo_reg - 5'd8;
                        end
                    end
                    3'd2: begin
                        if (norm_reg[31:28] == '0) begin
                            norm_next = norm_reg << 4;
                            expo_next = expo_reg - 5'd4;
                        end
                    end
                    3'd3: begin
                        if (norm_reg[31:30] == '0) begin
                            norm_next = norm_reg << 2;
                            expo_next = expo_reg - 5'd2;
                        end
                    end
                    default: begin
                        if (!norm_reg[31]) begin
                            norm_next = norm_reg << 1;
                            expo_next = expo_reg - 5'd1;
                        end
                    end
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd4) begin
                    state_next = ST_LOG_MUL;
                end
            end
            ST_LOG_MUL: begin
                mul_a      = $signed(33'(rr));
                mul_b      = 27'(tab_hi - tab_lo);
                mul_en     = 1'b1;
                state_next = ST_LOG_SUM;
            end
            ST_LOG_SUM: begin
                lg_next    = 22'({expo_reg, 16'h0000}) + 22'(tab_lo) + 22'(frac);
                state_next = ST_DB_MUL;
            end
            ST_DB_MUL: begin
                mul_a      = $signed(33'(lg_reg)) - (search_reg ? OFFSET16_Q16 : OFFSET31_Q16);
                mul_b      = DB_PER_OCT_Q24;
                mul_en     = 1'b1;
                state_next = ST_DB_UPD;
            end
            ST_DB_UPD: begin
                if (!search_reg) begin
                    level_next = (q24 < 37'(FLOOR_DB_Q16)) ? FLOOR_DB_Q16 : $signed(q24[23:0]);
                    state_next = ST_OVER;
                end else begin
                    if (q24 <= tgt) begin
                        lo_next = mid_reg;
                    end else begin
                        hi_next = mid_reg - 17'd1;
                    end
                    state_next = ST_SEARCH_CHK;
                end
            end
            ST_OVER: begin
                over_next  = 25'(level_reg) - 25'($signed({thr_reg, 8'h00}));
                state_next = ST_RT_MUL;
            end
            ST_RT_MUL: begin
                mul_a      = over_reg[24] ? 33'sd0 : $signed(33'(over_reg[23:0]));
                mul_b      = RATIO_SLOPE_Q16;
                mul_en     = 1'b1;
                state_next = ST_RT;
            end
            ST_RT: begin
                rt_next    = rtgt;
                state_next = ST_R_MUL;
            end
            ST_R_MUL: begin
                mul_a      = $signed(33'(rt_reg)) - $signed(33'(ratio_now_reg));
                mul_b      = 27'(smc_reg);
                mul_en     = 1'b1;
                state_next = ST_R_UPD;
            end
            ST_R_UPD: begin
                ratio_now_next = rsum[37] ? 24'd0 :
                                 ((rsum > 38'sh0FFFFFF) ? 24'hFFFFFF : rsum[23:0]);
                state_next     = ST_K_MUL;
            end
            ST_K_MUL: begin
                mul_a      = $signed(33'(ktgt)) - $signed(33'(knee_now_reg));
                mul_b      = 27'(smc_reg);
                mul_en     = 1'b1;
                state_next = ST_K_UPD;
            end
            ST_K_UPD: begin
                knee_now_next = k_new;
                if (two_over > ksn) begin
                    comp_next  = over_reg[23:0];
                    state_next = ST_RED_MUL;
                end else if (two_over > -ksn) begin
                    state_next = ST_P2_MUL;
                end else begin
                    comp_next  = '0;
                    state_next = ST_RED_MUL;
                end
            end
            ST_P2_MUL: begin
                mul_a      = 33'(p2);
                mul_b      = {1'b0, p2[25:0]};
                mul_en     = 1'b1;
                state_next = ST_P2_DIV;
            end
            ST_P2_DIV: begin
                rem_next   = prod_reg[51:0] + 52'({knee_now_reg, 2'b00});
                dsr_next   = 52'({knee_now_reg, 3'b000}) << (DIV_Q - 1);
                quo_next   = '0;
                cnt_next   = 5'(DIV_Q - 1);
                dsel_next  = 1'b0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // restoring divide, one quotient bit per cycle
                if (ge) begin
                    rem_next = rem_sub;
                end
                quo_next = {quo_reg[23:0], ge};
                dsr_next = dsr_reg >> 1;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0) begin
                    if (!dsel_reg) begin
                        comp_next  = {quo_reg[22:0], ge};
                        state_next = ST_RED_MUL;
                    end else begin
                        state_next = ST_MAG;
                    end
                end
            end
            ST_RED_MUL: begin
                if (ratio_now_reg > ONE_Q16) begin
                    mul_a      = $signed(33'(comp_reg));
                    mul_b      = 27'(ratio_now_reg - ONE_Q16);
                    mul_en     = 1'b1;
                    state_next = ST_RED_DIV;
                end else begin
                    quo_next   = '0;
                    state_next = ST_MAG;
                end
            end
            ST_RED_DIV: begin
                rem_next   = prod_reg[51:0] + 52'(ratio_now_reg >> 1);
                dsr_next   = 52'(ratio_now_reg) << (DIV_Q - 1);
                quo_next   = '0;
                cnt_next   = 5'(DIV_Q - 1);
                dsel_next  = 1'b1;
                state_next = ST_DIV;
            end
            ST_MAG: begin
                mag_next   = (mr > 17'd32768) ? 16'd32768 : mr[15:0];
                lo_next    = '0;
                hi_next    = 17'd65536;
                state_next = ST_SEARCH_CHK;
            end
            ST_SEARCH_CHK: begin
                if (lo_reg < hi_reg) begin
                    mid_next    = mid_sum[17:1];
                    norm_next   = 32'(mid_sum[17:1]);
                    expo_next   = 5'd31;
                    step_next   = '0;
                    search_next = 1'b1;
                    state_next  = ST_NORM;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {7'b0, 16'd0 - mag_reg, lo_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (mul_en) begin
            prod_next = mul_a * $signed({1'b0, mul_b});
        end
    end

endmodule

`default_nettype wire
